/* design/tpg_pkg.sv */
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared types, constants and helpers of the tone PWM generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned VOL_W    = 7;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PCNT_W   = 8;
  localparam int unsigned QUO_W    = 25;                 // holds 17000000
  localparam int unsigned DVS_W    = 16;
  localparam int unsigned PROD_W   = PERIOD_W + VOL_W;
  localparam int unsigned CNT_W    = $clog2(QUO_W);

  localparam logic [QUO_W-1:0]    TONE_CLOCK   = QUO_W'(17000000);
  localparam logic [QUO_W-1:0]    THRESH_256   = QUO_W'(4000000);
  localparam logic [QUO_W-1:0]    THRESH_64    = QUO_W'(500000);
  localparam logic [QUO_W-1:0]    THRESH_8     = QUO_W'(62500);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(999);
  localparam logic [PERIOD_W-1:0] DUTY_RESET   = PERIOD_W'(499);
  localparam logic [VOL_W-1:0]    PERCENT_FULL = VOL_W'(100);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PLAY   = 2'd1,
    OP_STOP   = 2'd2,
    OP_VOLUME = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PS_DIV1   = 2'd0,
    PS_DIV8   = 2'd1,
    PS_DIV64  = 2'd2,
    PS_DIV256 = 2'd3
  } prescale_e;

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [PCNT_W-1:0] prescale_limit(input logic [1:0] sel);
    logic [PCNT_W-1:0] lim;
    unique case (prescale_e'(sel))
      PS_DIV1:   lim = PCNT_W'(0);
      PS_DIV8:   lim = PCNT_W'(7);
      PS_DIV64:  lim = PCNT_W'(63);
      PS_DIV256: lim = PCNT_W'(255);
      default:   lim = PCNT_W'(255);
    endcase
    return lim;
  endfunction

endpackage

/* design/tpg_if.sv */
// ----------------------------------------------------------------------------
// tpg_if
// Valid/ready channels for command requests and per-request results.
// ----------------------------------------------------------------------------
interface tpg_in_if import tpg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [FREQ_W-1:0]   freq;
  logic [VOL_W-1:0]    volume;

  modport source (output valid, output opcode, output freq, output volume, input ready);
  modport sink   (input valid, input opcode, input freq, input volume, output ready);
endinterface

interface tpg_out_if import tpg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                pin_level;
  logic                error;
  logic [PERIOD_W-1:0] period_value;
  logic [1:0]          prescale_code;

  modport source (output valid, output pin_level, output error, output period_value,
                  output prescale_code, input ready);
  modport sink   (input valid, input pin_level, input error, input period_value,
                  input prescale_code, output ready);
endinterface

/* design/tone_pwm_generator.sv */
// ----------------------------------------------------------------------------
// tone_pwm_generator
// Tone timer with prescaler and PWM pin, driven by tick/play/stop/volume requests.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | handshake
//  req_i   | in  | opcode, freq, volume                           | valid/ready
//  rsp_o   | out | pin_level, error, period_value, prescale_code  | valid/ready
//
//  tick, stop and zero-frequency play: result registered and valid in the cycle after accept.
//  play: states ST_DIV then ST_DONE, using the 25-step shared divider (17000000 / freq).
//  volume: period times volume is registered, then ST_MUL starts the same divider (by 100).
//  req_i.ready is low outside ST_IDLE (multiply, divide, done) and while an unread result blocks.
//  reset: period 999, duty 499, timer stopped, no pending result.
// ----------------------------------------------------------------------------
module tone_pwm_generator import tpg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  tpg_in_if.sink   req_i,
  tpg_out_if.source rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic                is_play_q, is_play_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [1:0]          sel_q, sel_d;
  logic                running_q, running_d;
  logic [PERIOD_W-1:0] shadow_q, shadow_d;
  logic [PERIOD_W-1:0] active_q, active_d;
  logic [PERIOD_W-1:0] tone_q, tone_d;
  logic [PCNT_W-1:0]   pcnt_q, pcnt_d;

  logic                out_valid_q, out_valid_d;
  logic                out_pin_q, out_err_q;
  logic [PERIOD_W-1:0] out_period_q;
  logic [1:0]          out_sel_q;

  logic                out_free;
  logic                accept;
  logic                load_out;
  logic                err_d;
  logic [VOL_W-1:0]    vol_clamp;
  logic [QUO_W-1:0]    q_scaled;
  logic [1:0]          q_sel;
  logic [QUO_W-1:0]    q_minus;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign vol_clamp   = (req_i.volume > PERCENT_FULL) ? PERCENT_FULL : req_i.volume;

  tpg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    div_req.start    = (accept && op_e'(req_i.opcode) == OP_PLAY && req_i.freq != '0)
                       || (state_q == ST_MUL);
    div_req.dividend = (state_q == ST_MUL) ? QUO_W'(prod_q) : TONE_CLOCK;
    div_req.divisor  = (state_q == ST_MUL) ? DVS_W'(PERCENT_FULL) : DVS_W'(req_i.freq);
  end

  // prescaler pick and period scaling for the play quotient
  always_comb begin
    priority if (div_rsp.quotient > THRESH_256) begin
      q_sel    = PS_DIV256;
      q_scaled = div_rsp.quotient >> 8;
    end else if (div_rsp.quotient > THRESH_64) begin
      q_sel    = PS_DIV64;
      q_scaled = div_rsp.quotient >> 6;
    end else if (div_rsp.quotient > THRESH_8) begin
      q_sel    = PS_DIV8;
      q_scaled = div_rsp.quotient >> 3;
    end else begin
      q_sel    = PS_DIV1;
      q_scaled = div_rsp.quotient;
    end
    q_minus = (q_scaled == '0) ? '0 : q_scaled - QUO_W'(1);
  end

  always_comb begin
    state_d   = state_q;
    is_play_d = is_play_q;
    prod_d    = prod_q;
    period_d  = period_q;
    sel_d     = sel_q;
    running_d = running_q;
    shadow_d  = shadow_q;
    active_d  = active_q;
    tone_d    = tone_q;
    pcnt_d    = pcnt_q;
    load_out  = 1'b0;
    err_d     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(req_i.opcode))
            OP_TICK: begin
              load_out = 1'b1;
              if (running_q) begin
                if (pcnt_q >= prescale_limit(sel_q)) begin
                  pcnt_d = '0;
                  if (tone_q >= period_q) begin
                    tone_d   = '0;
                    active_d = shadow_q;
                  end else begin
                    tone_d = tone_q + PERIOD_W'(1);
                  end
                end else begin
                  pcnt_d = pcnt_q + PCNT_W'(1);
                end
              end
            end
            OP_PLAY: begin
              if (req_i.freq == '0) begin
                load_out = 1'b1;
                err_d    = 1'b1;
              end else begin
                is_play_d = 1'b1;
                state_d   = ST_DIV;
              end
            end
            OP_STOP: begin
              load_out  = 1'b1;
              running_d = 1'b0;
            end
            OP_VOLUME: begin
              prod_d    = PROD_W'(period_q) * PROD_W'(vol_clamp);
              is_play_d = 1'b0;
              state_d   = ST_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          if (is_play_q) begin
            period_d  = (q_minus > QUO_W'({PERIOD_W{1'b1}})) ? '1 : q_minus[PERIOD_W-1:0];
            sel_d     = q_sel;
            running_d = 1'b1;
          end else begin
            shadow_d = div_rsp.quotient[PERIOD_W-1:0];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = load_out ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      is_play_q   <= 1'b0;
      period_q    <= PERIOD_RESET;
      sel_q       <= PS_DIV1;
      running_q   <= 1'b0;
      shadow_q    <= DUTY_RESET;
      active_q    <= DUTY_RESET;
      tone_q      <= '0;
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      is_play_q   <= is_play_d;
      period_q    <= period_d;
      sel_q       <= sel_d;
      running_q   <= running_d;
      shadow_q    <= shadow_d;
      active_q    <= active_d;
      tone_q      <= tone_d;
      pcnt_q      <= pcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (load_out) begin
      out_pin_q    <= running_d && (tone_d < active_d);
      out_err_q    <= err_d;
      out_period_q <= period_d;
      out_sel_q    <= sel_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.pin_level     = out_pin_q;
  assign rsp_o.error         = out_err_q;
  assign rsp_o.period_value  = out_period_q;
  assign rsp_o.prescale_code = out_sel_q;

`ifndef ASSERT_OFF
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_play_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.opcode == OP_PLAY && req_i.freq != '0) |=> state_q == ST_DIV)
    else $error("play request did not start the divider");

  a_pin_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.pin_level) |-> running_q)
    else $error("pin high in a result while the timer is stopped");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV) |-> !req_i.ready)
    else $error("request taken while a division is in flight");
`endif

endmodule

/* design/tpg_div.sv */
// ----------------------------------------------------------------------------
// tpg_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpg_div import tpg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [QUO_W-1:0] quo_q, quo_d;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W - 1);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit drops
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
